// File: sv/date_add_days_core_macros.svh
// Assertion macros shared by the date adder modules.
`ifndef DATE_ADD_DAYS_CORE_MACROS_SVH
`define DATE_ADD_DAYS_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define DAD_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("date_add_days_core: same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define DAD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("date_add_days_core: next-cycle check failed");

`else

`define DAD_ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define DAD_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/dad_pkg.sv
package dad_pkg;

    // Internal widths
    localparam int DAY_W  = 17;   // start day plus signed offset
    localparam int YEAR_W = 16;   // year can leave the 14-bit input range both ways
    localparam int YMOD_W = 14;   // year, then year mod 400
    localparam int K_W    = 3;    // shift count of the mod-400 reduction

    localparam logic [YMOD_W-1:0] LEAP_CYCLE = 14'd400;
    localparam logic [YMOD_W-1:0] LEAP_LAST  = 14'd399;
    localparam logic [K_W-1:0]    K_START    = 3'd5;   // 400 << 5 = 12800
    localparam logic [3:0]        MONTH_JAN  = 4'd1;
    localparam logic [3:0]        MONTH_FEB  = 4'd2;
    localparam logic [3:0]        MONTH_DEC  = 4'd12;
    localparam logic [YEAR_W-1:0] YEAR_OUT_MAX = 16'd16383;

    // Micro-operations of the datapath
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_REDUCE,
        OP_NORM,
        OP_EMIT
    } op_t;

    // Jump conditions
    typedef enum logic [1:0] {
        COND_IN_VALID,
        COND_K_ZERO,
        COND_NORM_DONE,
        COND_OUT_FREE
    } cond_t;

    typedef logic [1:0] step_t;

    localparam step_t STEP_IDLE   = 2'd0;
    localparam step_t STEP_REDUCE = 2'd1;
    localparam step_t STEP_NORM   = 2'd2;
    localparam step_t STEP_EMIT   = 2'd3;

    // One control word of the program
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
        logic  in_ready;
    } uword_t;

    // Sequencer to datapath
    typedef struct packed {
        op_t  op;
        logic fire;
    } ctl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic k_zero;
        logic norm_done;
        logic out_free;
    } stat_t;

    // Program ROM: a step holds until its condition is true, then jumps
    function automatic uword_t ucode_word(input step_t s);
        uword_t w;
        unique case (s)
            STEP_IDLE:   w = '{op: OP_LOAD,   cond: COND_IN_VALID,  target: STEP_REDUCE,
                               in_ready: 1'b1};
            STEP_REDUCE: w = '{op: OP_REDUCE, cond: COND_K_ZERO,    target: STEP_NORM,
                               in_ready: 1'b0};
            STEP_NORM:   w = '{op: OP_NORM,   cond: COND_NORM_DONE, target: STEP_EMIT,
                               in_ready: 1'b0};
            STEP_EMIT:   w = '{op: OP_EMIT,   cond: COND_OUT_FREE,  target: STEP_IDLE,
                               in_ready: 1'b0};
        endcase
        return w;
    endfunction

    // Month length; month is already clamped to 1..12
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            MONTH_FEB:                 len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // Leap test on the year taken mod 400 (0..399)
    function automatic logic is_leap(input logic [YMOD_W-1:0] r);
        return (r[1:0] == 2'b00) && (r != 14'd100) && (r != 14'd200) && (r != 14'd300);
    endfunction

endpackage

// File: sv/dad_sequencer.sv
`include "date_add_days_core_macros.svh"

module dad_sequencer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  dad_pkg::stat_t stat,
    output dad_pkg::ctl_t  ctl,
    output logic          in_stall
);
    import dad_pkg::*;

    step_t  upc_reg;
    step_t  upc_next;
    uword_t word;
    logic   cond_ok;

    // Fetch the control word and test its jump condition
    always_comb
    begin
        word = ucode_word(upc_reg);
        unique case (word.cond)
            COND_IN_VALID:  cond_ok = in_valid;
            COND_K_ZERO:    cond_ok = stat.k_zero;
            COND_NORM_DONE: cond_ok = stat.norm_done;
            COND_OUT_FREE:  cond_ok = stat.out_free;
        endcase
        ctl.op   = word.op;
        ctl.fire = cond_ok;
        in_stall = !word.in_ready;
        upc_next = cond_ok ? word.target : upc_reg;
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= STEP_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    `DAD_ASSERT_NEXT(a_load_to_reduce, clk, rst_n, ctl.op == OP_LOAD && ctl.fire, upc_reg == STEP_REDUCE)

endmodule

// File: sv/dad_datapath.sv
`include "date_add_days_core_macros.svh"

module dad_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  dad_pkg::ctl_t  ctl,
    output dad_pkg::stat_t stat,
    input  logic [4:0]     start_day,
    input  logic [3:0]     start_month,
    input  logic [13:0]    start_year,
    input  logic signed [15:0] day_delta,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [4:0]     result_day,
    output logic [3:0]     result_month,
    output logic signed [14:0] result_year,
    output logic           date_valid
);
    import dad_pkg::*;

    logic signed [DAY_W-1:0]  day_reg,   day_next;
    logic [3:0]               month_reg, month_next;
    logic signed [YEAR_W-1:0] year_reg,  year_next;
    logic [YMOD_W-1:0]        ymod_reg,  ymod_next;
    logic [K_W-1:0]           k_reg,     k_next;

    logic                     out_valid_reg;
    logic [4:0]               out_day_reg;
    logic [3:0]               out_month_reg;
    logic signed [14:0]       out_year_reg;
    logic                     out_date_valid_reg;

    logic [YMOD_W-1:0]        sub_val;
    logic                     leap;
    logic [4:0]               cur_len;
    logic [4:0]               prev_len;
    logic [3:0]               prev_month;
    logic [3:0]               clamp_month;
    logic                     day_low;
    logic                     day_high;
    logic                     year_ok;

    // Status toward the sequencer
    always_comb
    begin
        leap     = is_leap(ymod_reg);
        cur_len  = month_len(month_reg, leap);
        day_low  = day_reg[DAY_W-1] || (day_reg == '0);
        day_high = day_reg > $signed({{(DAY_W-5){1'b0}}, cur_len});
        // Going back from March keeps the year, so the same leap flag serves
        prev_month = (month_reg == MONTH_JAN) ? MONTH_DEC : month_reg - 4'd1;
        prev_len   = month_len(prev_month, leap);
        sub_val    = LEAP_CYCLE << k_reg;

        stat.k_zero    = (k_reg == '0);
        stat.norm_done = !day_low && !day_high;
        stat.out_free  = !out_valid_reg || !out_stall;
    end

    // Datapath next values, one micro-operation per cycle
    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        ymod_next  = ymod_reg;
        k_next     = k_reg;
        clamp_month = start_month;
        if (start_month < MONTH_JAN)
        begin
            clamp_month = MONTH_JAN;
        end
        else if (start_month > MONTH_DEC)
        begin
            clamp_month = MONTH_DEC;
        end

        unique case (ctl.op)
            OP_LOAD:
            begin
                if (ctl.fire)
                begin
                    day_next   = $signed({{(DAY_W-5){1'b0}}, start_day})
                               + $signed({day_delta[15], day_delta});
                    month_next = clamp_month;
                    year_next  = $signed({{(YEAR_W-14){1'b0}}, start_year});
                    ymod_next  = start_year;
                    k_next     = K_START;
                end
            end
            OP_REDUCE:
            begin
                // Restoring reduction of the year mod 400, one shift per step
                if (ymod_reg >= sub_val)
                begin
                    ymod_next = ymod_reg - sub_val;
                end
                if (!stat.k_zero)
                begin
                    k_next = k_reg - 3'd1;
                end
            end
            OP_NORM:
            begin
                if (day_high)
                begin
                    // Carry into the next month
                    day_next = day_reg - $signed({{(DAY_W-5){1'b0}}, cur_len});
                    if (month_reg == MONTH_DEC)
                    begin
                        month_next = MONTH_JAN;
                        year_next  = year_reg + 16'sd1;
                        ymod_next  = (ymod_reg == LEAP_LAST) ? '0 : ymod_reg + 14'd1;
                    end
                    else
                    begin
                        month_next = month_reg + 4'd1;
                    end
                end
                else if (day_low)
                begin
                    // Borrow from the previous month
                    day_next   = day_reg + $signed({{(DAY_W-5){1'b0}}, prev_len});
                    month_next = prev_month;
                    if (month_reg == MONTH_JAN)
                    begin
                        year_next = year_reg - 16'sd1;
                        ymod_next = (ymod_reg == '0) ? LEAP_LAST : ymod_reg - 14'd1;
                    end
                end
            end
            OP_EMIT:
            begin
            end
        endcase
    end

    // Hold working registers
    always_ff @(posedge clk)
    begin
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        ymod_reg  <= ymod_next;
        k_reg     <= k_next;
    end

    assign year_ok = !year_reg[YEAR_W-1] && (year_reg != '0)
                   && ($unsigned(year_reg) <= YEAR_OUT_MAX);

    // Load the output beat
    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_EMIT && ctl.fire)
        begin
            out_day_reg        <= day_reg[4:0];
            out_month_reg      <= month_reg;
            out_year_reg       <= year_reg[14:0];
            out_date_valid_reg <= year_ok;
        end
    end

    // Output valid: set on emit, drop when the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.op == OP_EMIT && ctl.fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_day   = out_day_reg;
    assign result_month = out_month_reg;
    assign result_year  = out_year_reg;
    assign date_valid   = out_date_valid_reg;

    `DAD_ASSERT_IMPLIES(a_norm_month, clk, rst_n, ctl.op == OP_NORM, month_reg >= MONTH_JAN && month_reg <= MONTH_DEC)
    `DAD_ASSERT_IMPLIES(a_norm_ymod, clk, rst_n, ctl.op == OP_NORM, ymod_reg < LEAP_CYCLE)
    `DAD_ASSERT_NEXT(a_emit_sets_valid, clk, rst_n, ctl.op == OP_EMIT && ctl.fire, out_valid_reg && out_day_reg != 5'd0)

endmodule

// File: sv/date_add_days_core.sv
// Channel | Handshake                     | Beat
// --------+-------------------------------+------------------------------------------------
// in      | in_valid / in_stall           | start_day, start_month, start_year, day_delta
// out     | out_valid / out_stall         | result_day, result_month, result_year, date_valid
//
// One item at a time: a load step, the shift-and-subtract reduction of the year
// mod 400, one step per month crossed plus a final check, then an emit step.
// The month walk in the datapath, one month per cycle, takes longest for large offsets.
// Reset clears the step counter and output valid; no clearing pass.
// A stalled output holds the emit step, and with it the input stall.
module date_add_days_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [4:0]        start_day,
    input  logic [3:0]        start_month,
    input  logic [13:0]       start_year,
    input  logic signed [15:0] day_delta,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [4:0]        result_day,
    output logic [3:0]        result_month,
    output logic signed [14:0] result_year,
    output logic              date_valid
);
    import dad_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    dad_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .ctl      (ctl),
        .in_stall (in_stall)
    );

    dad_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .start_day    (start_day),
        .start_month  (start_month),
        .start_year   (start_year),
        .day_delta    (day_delta),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_day   (result_day),
        .result_month (result_month),
        .result_year  (result_year),
        .date_valid   (date_valid)
    );

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // One normalized date as the block reports it
    typedef struct packed {
        logic [4:0]        day;
        logic [3:0]        month;
        logic signed [14:0] year;
        logic              date_valid;
    } date_t;

    // Directed beat; the answer is typed in only where it is obvious
    typedef struct packed {
        logic [4:0]         day;
        logic [3:0]         month;
        logic [13:0]        year;
        logic signed [15:0] delta;
        logic               known;
        date_t              want;
    } row_t;

    localparam int DIRECTED_ROWS = 24;
    localparam int RANDOM_ITEMS  = 480;
    localparam int CALM_ITEMS    = 60;
    localparam int HOLD_CYCLES   = 3000;
    localparam int HOLD_AFTER    = 40;
    localparam int DRAIN_CYCLES  = 50;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [4:0]         start_day = '0;
    logic [3:0]         start_month = '0;
    logic [13:0]        start_year = '0;
    logic signed [15:0] day_delta = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [4:0]         result_day;
    logic [3:0]         result_month;
    logic signed [14:0] result_year;
    logic               date_valid;

    date_t pending_dates [$];
    int    errors = 0;
    int    results_seen = 0;
    bit    calm = 1'b0;

    row_t plan [DIRECTED_ROWS] = '{
        '{5'd15, 4'd6,  14'd2000,  16'sd0,  1'b1, '{5'd15, 4'd6,  15'sd2000,  1'b1}},
        '{5'd1,  4'd1,  14'd1,     -16'sd1, 1'b1, '{5'd31, 4'd12, 15'sd0,     1'b0}},
        '{5'd31, 4'd12, 14'd9999,  16'sd1,  1'b1, '{5'd1,  4'd1,  15'sd10000, 1'b1}},
        '{5'd28, 4'd2,  14'd2000,  16'sd1,  1'b1, '{5'd29, 4'd2,  15'sd2000,  1'b1}},
        '{5'd28, 4'd2,  14'd1900,  16'sd1,  1'b1, '{5'd1,  4'd3,  15'sd1900,  1'b1}},
        '{5'd28, 4'd2,  14'd2400,  16'sd1,  1'b1, '{5'd29, 4'd2,  15'sd2400,  1'b1}},
        '{5'd0,  4'd3,  14'd2024,  16'sd0,  1'b1, '{5'd29, 4'd2,  15'sd2024,  1'b1}},
        '{5'd15, 4'd0,  14'd2020,  16'sd0,  1'b1, '{5'd15, 4'd1,  15'sd2020,  1'b1}},
        '{5'd15, 4'd15, 14'd2020,  16'sd0,  1'b1, '{5'd15, 4'd12, 15'sd2020,  1'b1}},
        '{5'd31, 4'd4,  14'd2023,  16'sd0,  1'b1, '{5'd1,  4'd5,  15'sd2023,  1'b1}},
        '{5'd31, 4'd12, 14'd16383, 16'sd1,  1'b1, '{5'd1,  4'd1,  15'h4000,   1'b0}},
        '{5'd1,  4'd1,  14'd0,     16'sd0,  1'b1, '{5'd1,  4'd1,  15'sd0,     1'b0}},
        '{5'd1,  4'd3,  14'd0,     -16'sd1, 1'b1, '{5'd29, 4'd2,  15'sd0,     1'b0}},
        '{5'd0,  4'd1,  14'd1,     16'sd0,  1'b1, '{5'd31, 4'd12, 15'sd0,     1'b0}},
        '{5'd31, 4'd1,  14'd2023,  16'sd1,  1'b1, '{5'd1,  4'd2,  15'sd2023,  1'b1}},
        '{5'd1,  4'd1,  14'd1,     16'h8000, 1'b0, '0},
        '{5'd31, 4'd12, 14'd16383, 16'h7FFF, 1'b0, '0},
        '{5'd0,  4'd0,  14'd0,     16'h8000, 1'b0, '0},
        '{5'd31, 4'd15, 14'd16383, 16'h8000, 1'b0, '0},
        '{5'd1,  4'd1,  14'd2000,  16'h7FFF, 1'b0, '0},
        '{5'd31, 4'd2,  14'd2023,  16'sd0,   1'b0, '0},
        '{5'd0,  4'd13, 14'd2100,  -16'sd59, 1'b0, '0},
        '{5'd17, 4'd9,  14'd1583,  16'sd12345, 1'b0, '0},
        '{5'd31, 4'd12, 14'd1,     -16'sd800, 1'b0, '0}
    };

    date_add_days_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .start_day    (start_day),
        .start_month  (start_month),
        .start_year   (start_year),
        .day_delta    (day_delta),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_day   (result_day),
        .result_month (result_month),
        .result_year  (result_year),
        .date_valid   (date_valid)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Gregorian leap rule on the signed year, year 0 and below included
    function automatic bit leap_year(input int yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic int days_in_month(input int mon, input int yr);
        case (mon)
            2:             return leap_year(yr) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // Add the offset and walk month by month until the day fits
    function automatic date_t add_days(input logic [4:0] d, input logic [3:0] m,
                                       input logic [13:0] y,
                                       input logic signed [15:0] delta);
        int    day;
        int    mon;
        int    yr;
        date_t r;
        day = int'(d);
        mon = int'(m);
        yr  = int'(y);
        day += int'(delta);
        if (mon < 1)
            mon = 1;
        if (mon > 12)
            mon = 12;
        while (day > days_in_month(mon, yr) || day < 1)
        begin
            if (day > days_in_month(mon, yr))
            begin
                day -= days_in_month(mon, yr);
                mon += 1;
                if (mon > 12)
                begin
                    mon = 1;
                    yr += 1;
                end
            end
            else
            begin
                mon -= 1;
                if (mon < 1)
                begin
                    mon = 12;
                    yr -= 1;
                end
                day += days_in_month(mon, yr);
            end
        end
        r.day        = day[4:0];
        r.month      = mon[3:0];
        r.year       = yr[14:0];
        r.date_valid = (yr >= 1) && (yr <= 16383);
        return r;
    endfunction

    // Present one beat and hold it until the block takes it
    task automatic offer_date(input logic [4:0] d, input logic [3:0] m,
                              input logic [13:0] y, input logic signed [15:0] delta,
                              input date_t want);
        in_valid    <= 1'b1;
        start_day   <= d;
        start_month <= m;
        start_year  <= y;
        day_delta   <= delta;
        do
            @(posedge clk);
        while (in_stall);
        pending_dates.push_back(want);
    endtask

    // Drop valid for a random burst now and then
    task automatic sender_gap();
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic compare_field(input string name, input logic signed [31:0] want_v,
                                 input logic signed [31:0] got_v);
        if (got_v !== want_v)
        begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
        end
    endtask

    // Stimulus: directed rows, then random dates
    initial
    begin : stimulus
        logic [4:0]         d;
        logic [3:0]         m;
        logic [13:0]        y;
        logic signed [15:0] delta;
        date_t              want;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (plan[i])
        begin
            want = plan[i].known ? plan[i].want
                 : add_days(plan[i].day, plan[i].month, plan[i].year, plan[i].delta);
            offer_date(plan[i].day, plan[i].month, plan[i].year, plan[i].delta, want);
            sender_gap();
        end
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            d = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 31));
            m = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 12));
            y = ($urandom_range(0, 4) == 0) ? 14'($urandom) : 14'($urandom_range(1, 9999));
            if ($urandom_range(0, 2) == 0)
                delta = 16'(int'($urandom_range(0, 800)) - 400);
            else
                delta = 16'($urandom);
            offer_date(d, m, y, delta, add_days(d, m, y, delta));
            sender_gap();
        end
        in_valid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Receiver stall: random bursts, one long hold, none at the end
    initial
    begin : receiver
        bit held;
        held = 1'b0;
        wait (rst_n);
        forever
        begin
            if (calm)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    // Check each accepted result beat against the oldest expected date
    always @(posedge clk)
    begin
        date_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_dates.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %0d/%0d/%0d valid %0d", $time,
                         result_day, result_month, result_year, date_valid);
            end
            else
            begin
                want = pending_dates.pop_front();
                compare_field("result_day", int'(want.day), int'(result_day));
                compare_field("result_month", int'(want.month), int'(result_month));
                compare_field("result_year", int'(want.year), int'(result_year));
                compare_field("date_valid", int'(want.date_valid), int'(date_valid));
            end
        end
    end

    // Hard limit on run time
    initial
    begin
        #40_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
